/* hdl/frsha_pkg.sv */
// Shared types and constants for the frame-ring state-heap allocator.
// No dependencies; imported by every module of the block.
package frsha_pkg;

	localparam int MAX_SLOTS_DEF = 8;
	localparam int ZONE_GRAIN    = 64;
	localparam int CFG_W         = 24;
	localparam int CAP_W         = 25;
	localparam int OFFSET_W      = 28;
	localparam int FENCE_W       = 64;

	localparam logic [1:0] FUNC_PALLOC = 2'd0;
	localparam logic [1:0] FUNC_TALLOC = 2'd1;
	localparam logic [1:0] FUNC_BEGIN  = 2'd2;
	localparam logic [1:0] FUNC_END    = 2'd3;

	localparam logic [1:0] CFG_PERSISTENT_BYTES = 2'd0;
	localparam logic [1:0] CFG_FRAME_BYTES      = 2'd1;
	localparam logic [1:0] CFG_FRAME_SLOTS      = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [23:0]        size;
		logic [4:0]         align_log2;
		logic [FENCE_W-1:0] seqno;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [OFFSET_W-1:0] offset;
		logic [FENCE_W-1:0]  fence;
	} rsp_t;

	// fence store control
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} fence_ctl_t;

	// zone size rounded up to a multiple of ZONE_GRAIN
	function automatic logic [CAP_W-1:0] round_zone(input logic [CFG_W-1:0] v);
		logic [CAP_W-1:0] s;
		s = {1'b0, v} + CAP_W'(ZONE_GRAIN - 1);
		return s & ~CAP_W'(ZONE_GRAIN - 1);
	endfunction

endpackage

/* hdl/frsha_fence_ram.sv */
// Per-slot fence store: one synchronous RAM with a registered read.
// Per-entry valid flops give the all-zero reset and the clear on config.
// Depends on frsha_pkg.
module frsha_fence_ram import frsha_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fence_ctl_t         ctl,
	input  logic [SLOT_W-1:0]  rd_addr,
	input  logic [SLOT_W-1:0]  wr_addr,
	input  logic [FENCE_W-1:0] wr_data,
	output logic [FENCE_W-1:0] rd_data
);

	logic [FENCE_W-1:0] mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] vld_q;
	logic [FENCE_W-1:0] rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written slot reads as zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

/* hdl/frame_ring_state_heap_allocator.sv */
// Top level of the frame-ring state-heap allocator: request decode, cursors,
// slot ring and result register. Depends on frsha_pkg and frsha_fence_ram.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+------------------------------------
//  request  | start, busy, req             | taken when start && !busy
//  result   | done, rsp                    | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_index, cfg_data  | cfg_we, idx 0..2; idle, user-enforced
//
// Per item, the accept cycle reads the fence RAM and precomputes the slot
// base; the next cycle (busy high) does the align, add and compare and
// updates the cursors. done pulses the cycle after that, while a new item
// may already be taken; no new item is taken while busy is high.
// Reset clears all control state; the fence store needs no clearing pass,
// its per-slot valid flops clear at once. The receiver cannot stall.
module frame_ring_state_heap_allocator import frsha_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1) > 4 ? $clog2(MAX_SLOTS + 1) : 4;
	localparam int PROD_W = SLOT_W + CAP_W;
	localparam int ALN_W  = 33;   // cursor plus an alignment mask of up to 31 bits
	localparam int END_W  = ALN_W + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	// configuration registers
	logic [CFG_W-1:0] pbytes_q;
	logic [CFG_W-1:0] fbytes_q;
	logic [3:0]       fslots_q;

	// allocator state
	logic              state_q;
	logic [CAP_W-1:0]  pcur_q;
	logic [CAP_W-1:0]  fcur_q;
	logic [SLOT_W-1:0] slot_q;
	logic              started_q;

	// request held for the exec cycle
	req_t                req_s1;
	logic [SLOT_W-1:0]   nslot_s1;
	logic [OFFSET_W-1:0] base_s1;

	logic                done_q;
	rsp_t                rsp_q;
	rsp_t                rsp_d;

	logic [CAP_W-1:0]  pcap, fcap;
	logic [CNT_W-1:0]  cnt;
	logic [SLOT_W-1:0] nslot;
	logic              accept;
	logic              cfg_hit;
	logic [PROD_W-1:0] prod;

	fence_ctl_t         fctl;
	logic [FENCE_W-1:0] fence_rd;

	logic [ALN_W-1:0] amask, acur, astart;
	logic [END_W-1:0] aend;
	logic [CAP_W-1:0] acap;
	logic             fit;

	assign pcap = round_zone(pbytes_q);
	assign fcap = round_zone(fbytes_q);

	// slot count clamped to 1..MAX_SLOTS
	always_comb begin
		if (fslots_q == 4'd0) begin
			cnt = CNT_W'(1);
		end else if (CNT_W'(fslots_q) > CNT_W'(MAX_SLOTS)) begin
			cnt = CNT_W'(MAX_SLOTS);
		end else begin
			cnt = CNT_W'(fslots_q);
		end
	end

	// slot made current by a begin frame; first begin stays put
	always_comb begin
		if (!started_q) begin
			nslot = slot_q;
		end else if (CNT_W'(slot_q) + CNT_W'(1) >= cnt) begin
			nslot = '0;
		end else begin
			nslot = slot_q + SLOT_W'(1);
		end
	end

	assign busy    = (state_q == ST_EXEC);
	assign accept  = start && !busy;
	assign cfg_hit = cfg_we && (cfg_index == CFG_PERSISTENT_BYTES ||
		cfg_index == CFG_FRAME_BYTES || cfg_index == CFG_FRAME_SLOTS);

	// transient base of the current slot, formed while the RAM is read
	assign prod = PROD_W'(slot_q) * PROD_W'(fcap);

	always_comb begin
		fctl.rd_en = accept;
		fctl.wr_en = busy && (req_s1.func == FUNC_END);
		fctl.clr   = cfg_hit;
	end

	frsha_fence_ram #(
		.MAX_SLOTS(MAX_SLOTS),
		.SLOT_W   (SLOT_W)
	) u_fence (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fctl),
		.rd_addr(nslot),
		.wr_addr(slot_q),
		.wr_data(req_s1.seqno),
		.rd_data(fence_rd)
	);

	// align the selected cursor up, add the size, compare against the zone
	always_comb begin
		amask  = (ALN_W'(1) << req_s1.align_log2) - ALN_W'(1);
		acur   = (req_s1.func == FUNC_PALLOC) ? ALN_W'(pcur_q) : ALN_W'(fcur_q);
		acap   = (req_s1.func == FUNC_PALLOC) ? pcap : fcap;
		astart = (acur + amask) & ~amask;
		aend   = END_W'(astart) + END_W'(req_s1.size);
		fit    = aend <= END_W'(acap);
	end

	// result of the item in exec; unused fields stay zero
	always_comb begin
		rsp_d = '0;
		case (req_s1.func)
			FUNC_PALLOC: begin
				rsp_d.ok = fit;
				if (fit) begin
					rsp_d.offset = astart[OFFSET_W-1:0];
				end
			end
			FUNC_TALLOC: begin
				rsp_d.ok = fit;
				if (fit) begin
					rsp_d.offset = base_s1 + astart[OFFSET_W-1:0];
				end
			end
			FUNC_BEGIN: begin
				rsp_d.ok    = 1'b1;
				rsp_d.fence = fence_rd;
			end
			default: begin
				rsp_d.ok = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req;
			nslot_s1 <= nslot;
			base_s1  <= OFFSET_W'(pcap) + OFFSET_W'(prod);
		end
		if (busy) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbytes_q  <= '0;
			fbytes_q  <= '0;
			fslots_q  <= 4'd1;
			state_q   <= ST_IDLE;
			pcur_q    <= '0;
			fcur_q    <= '0;
			slot_q    <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= busy;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// any register write clears the allocator state
			if (cfg_hit) begin
				case (cfg_index)
					CFG_PERSISTENT_BYTES: pbytes_q <= cfg_data;
					CFG_FRAME_BYTES:      fbytes_q <= cfg_data;
					default:              fslots_q <= cfg_data[3:0];
				endcase
				pcur_q    <= '0;
				fcur_q    <= '0;
				slot_q    <= '0;
				started_q <= 1'b0;
			end else if (busy) begin
				case (req_s1.func)
					FUNC_PALLOC: begin
						if (fit) begin
							pcur_q <= aend[CAP_W-1:0];
						end
					end
					FUNC_TALLOC: begin
						if (fit) begin
							fcur_q <= aend[CAP_W-1:0];
						end
					end
					FUNC_BEGIN: begin
						started_q <= 1'b1;
						slot_q    <= nslot_s1;
						fcur_q    <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
